[rtl/lobm_pkg.sv]
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

	localparam int unsigned MAX_RESULTS = 64;

	localparam logic [2:0] ST_NONE      = 3'd0;
	localparam logic [2:0] ST_FILLED    = 3'd1;
	localparam logic [2:0] ST_RESTED    = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	localparam logic REQ_NEW    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;
	localparam logic SIDE_BUY   = 1'b0;
	localparam logic SIDE_SELL  = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic load;        // capture request
		logic scan_start;  // clear scan accumulators, point at slot 0
		logic scan_step;   // examine one slot
		logic fill;        // apply fill to the best slot
		logic rest;        // write remainder into the free slot
		logic cancel;      // clear the matching slot
		logic emit;        // load the output register
		logic emit_last;   // item is final
		logic emit_trade;  // item is a fill
		logic [2:0] emit_status;
	} lobm_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_cancel;
		logic qty_zero;
		logic scan_done;    // last slot examined on this step
		logic best_found;
		logic free_found;
		logic id_found;
		logic out_busy;     // output register still holds an item
		logic fill_cap;     // fill count reached the limit
	} lobm_sts_t;

endpackage

[rtl/lobm_datapath.sv]
// Slot store, sequential best-order scan, fill arithmetic and output register.
module lobm_datapath import lobm_pkg::*; #(
	parameter int unsigned ORDER_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lobm_cmd_t        cmd,
	output lobm_sts_t        sts,
	input  logic             in_req,
	input  logic [224:0]     in_data,
	input  logic             out_take,
	output logic             out_valid,
	output logic [191:0]     out_data,
	output logic [4:0]       out_user
);

	localparam int unsigned IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

	// Slot memory: one row holds every field of a resting order.
	typedef struct packed {
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		logic [63:0] oid;
		logic [31:0] trader;
		logic [31:0] seq;
	} slot_t;

	slot_t            mem_q [ORDER_SLOTS];
	slot_t            rd_q;
	logic [ORDER_SLOTS-1:0] valid_q;

	logic        req_q, side_q;
	logic [31:0] limit_q, qty_q, trader_q, arrival_q;
	logic [63:0] id_q, ts_q;

	logic [IW:0]   idx_q;      // address issued to memory
	logic [IW-1:0] rd_idx_q;   // address of rd_q
	logic          rd_vld_q;
	logic [IW-1:0] best_q, free_q, hit_q;
	logic          best_ok_q, free_ok_q, hit_ok_q;
	logic [31:0]   best_price_q, best_age_q, best_qty_q, best_trader_q;
	logic [RW-1:0] nfill_q;

	logic         out_valid_q;
	logic [191:0] out_data_q;
	logic [4:0]   out_user_q;

	logic [31:0] age;
	logic        cand, better, rv;
	logic [31:0] m;

	always_comb begin
		rv     = rd_vld_q && valid_q[rd_idx_q];
		age    = arrival_q - rd_q.seq;
		cand   = rv && (rd_q.side != side_q) &&
		         ((side_q == SIDE_BUY) ? (rd_q.price <= limit_q) : (rd_q.price >= limit_q));
		if (!best_ok_q)
			better = 1'b1;
		else if (rd_q.price != best_price_q)
			better = (side_q == SIDE_BUY) ? (rd_q.price < best_price_q)
			                              : (rd_q.price > best_price_q);
		else
			better = age > best_age_q;
		m = (qty_q < best_qty_q) ? qty_q : best_qty_q;
	end

	// Memory read and write: one row a cycle.
	always_ff @(posedge clk) begin
		if (cmd.scan_start || cmd.scan_step)
			rd_q <= mem_q[idx_q[IW-1:0]];
		if (cmd.rest)
			mem_q[free_q] <= '{side: side_q, price: limit_q, qty: qty_q, oid: id_q,
			                   trader: trader_q, seq: arrival_q};
		else if (cmd.fill)
			mem_q[best_q].qty <= best_qty_q - m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			arrival_q     <= '0;
			qty_q         <= '0;
			idx_q         <= '0;
			rd_idx_q      <= '0;
			rd_vld_q      <= 1'b0;
			best_q        <= '0;
			free_q        <= '0;
			hit_q         <= '0;
			best_ok_q     <= 1'b0;
			free_ok_q     <= 1'b0;
			hit_ok_q      <= 1'b0;
			best_price_q  <= '0;
			best_age_q    <= '0;
			best_qty_q    <= '0;
			best_trader_q <= '0;
			nfill_q       <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
			out_user_q    <= '0;
		end else begin
			if (cmd.load) begin
				nfill_q <= '0;
				qty_q   <= in_data[64:33];
			end
			if (cmd.scan_start) begin
				rd_idx_q  <= idx_q[IW-1:0];
				idx_q     <= '0;
				rd_vld_q  <= 1'b0;
				best_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
				hit_ok_q  <= 1'b0;
			end
			if (cmd.scan_step) begin
				rd_vld_q <= (idx_q < (IW+1)'(ORDER_SLOTS));
				rd_idx_q <= idx_q[IW-1:0];
				if (idx_q < (IW+1)'(ORDER_SLOTS))
					idx_q <= idx_q + 1'b1;
				if (rd_vld_q && !valid_q[rd_idx_q] && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q    <= rd_idx_q;
				end
				if (rv && rd_q.oid == id_q && !hit_ok_q) begin
					hit_ok_q <= 1'b1;
					hit_q    <= rd_idx_q;
				end
				if (cand && better) begin
					best_ok_q     <= 1'b1;
					best_q        <= rd_idx_q;
					best_price_q  <= rd_q.price;
					best_age_q    <= age;
					best_qty_q    <= rd_q.qty;
					best_trader_q <= rd_q.trader;
				end
			end
			if (cmd.fill) begin
				qty_q   <= qty_q - m;
				nfill_q <= nfill_q + 1'b1;
				if (best_qty_q == m)
					valid_q[best_q] <= 1'b0;
			end
			if (cmd.rest) begin
				valid_q[free_q] <= 1'b1;
				arrival_q       <= arrival_q + 1'b1;
			end
			if (cmd.cancel)
				valid_q[hit_q] <= 1'b0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				out_user_q  <= {cmd.emit_last, cmd.emit_status, cmd.emit_trade};
				if (cmd.emit_trade)
					out_data_q <= {ts_q, m, best_price_q,
					               (side_q == SIDE_BUY) ? best_trader_q : trader_q,
					               (side_q == SIDE_BUY) ? trader_q : best_trader_q};
				else
					out_data_q <= '0;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request register: capture fields on acceptance.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= in_req;
			side_q   <= in_data[0];
			limit_q  <= in_data[32:1];
			id_q     <= in_data[128:65];
			trader_q <= in_data[160:129];
			ts_q     <= in_data[224:161];
		end
	end

	always_comb begin
		sts.is_cancel  = req_q;
		sts.qty_zero   = (qty_q == '0);
		sts.scan_done  = cmd.scan_step && rd_vld_q &&
		                 (rd_idx_q == IW'(ORDER_SLOTS - 1));
		sts.best_found = best_ok_q;
		sts.free_found = free_ok_q;
		sts.id_found   = hit_ok_q;
		sts.out_busy   = out_valid_q && !out_take;
		sts.fill_cap   = (nfill_q == RW'(MAX_RESULTS));
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

[rtl/lobm_ctrl.sv]
// Request sequencer for the order book: scan, fill, rest, cancel, report.
module lobm_ctrl import lobm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	output logic      in_ready,
	output lobm_cmd_t cmd,
	input  lobm_sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_SCAN  = 6'b000100,
		S_DEC   = 6'b001000,
		S_FILL  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t   state_q, state_d;
	logic [2:0] pend_status_q, pend_status_d;

	always_comb begin
		state_d       = state_q;
		pend_status_d = pend_status_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done)
					state_d = S_DEC;
			end
			S_DEC: begin
				// Decide next action from the finished scan.
				if (sts.is_cancel) begin
					cmd.cancel    = sts.id_found;
					pend_status_d = sts.id_found ? ST_CANCELLED : ST_NOT_FOUND;
					state_d       = S_EMIT;
				end else if (!sts.qty_zero && !sts.fill_cap && sts.best_found) begin
					state_d = S_FILL;
				end else begin
					if (sts.qty_zero)
						pend_status_d = ST_FILLED;
					else if (sts.free_found) begin
						cmd.rest      = 1'b1;
						pend_status_d = ST_RESTED;
					end else
						pend_status_d = ST_DROPPED;
					state_d = S_EMIT;
				end
			end
			S_FILL: begin
				// Fill items wait for the output register; final status rides later.
				if (!sts.out_busy) begin
					cmd.emit        = 1'b1;
					cmd.emit_trade  = 1'b1;
					cmd.fill        = 1'b1;
					cmd.emit_status = ST_NONE;
					// Emit every fill as non-final; the output stage merges the
					// final status onto the last one.
					state_d = S_START;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = pend_status_q;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pend_status_q <= ST_NONE;
		end else begin
			state_q       <= state_d;
			pend_status_q <= pend_status_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	a_rest_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rest && cmd.cancel)) else $error("rest and cancel together");
	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy) else $error("emit over a held item");

endmodule

[rtl/lobm_outq.sv]
// Final-status merger: holds the latest fill so the status can ride on it.
module lobm_outq import lobm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [191:0] in_data,
	input  logic [4:0]   in_user,
	output logic         in_take,
	output logic         tvalid,
	input  logic         tready,
	output logic [199:0] tdata,
	output logic         tuser,
	output logic         tlast
);

	// Hold one fill back; a status-only item that follows a fill merges into it.
	// in_user: is_trade[0] status[3:1] last[4]
	logic         hold_q;
	logic [191:0] hdata_q;
	logic [4:0]   huser_q;
	logic         ovalid_q;
	logic [191:0] odata_q;
	logic [4:0]   ouser_q;
	logic         in_trade, can_push, load_out;

	assign in_trade = in_user[0];
	assign can_push = !ovalid_q || tready;
	assign in_take  = in_valid && (can_push || (!hold_q && in_trade));
	assign load_out = in_take && (hold_q || !in_trade);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 1'b0;
			hdata_q  <= '0;
			huser_q  <= '0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			ouser_q  <= '0;
		end else begin
			if (load_out)
				ovalid_q <= 1'b1;
			else if (tready)
				ovalid_q <= 1'b0;
			if (in_take) begin
				if (hold_q) begin
					odata_q <= hdata_q;
					if (!in_trade) begin
						ouser_q <= {in_user[4:1], huser_q[0]};
						hold_q  <= 1'b0;
					end else begin
						ouser_q <= huser_q;
						hdata_q <= in_data;
						huser_q <= in_user;
					end
				end else if (in_trade) begin
					hold_q  <= 1'b1;
					hdata_q <= in_data;
					huser_q <= in_user;
				end else begin
					odata_q <= in_data;
					ouser_q <= in_user;
				end
			end
		end
	end

	assign tvalid = ovalid_q;
	assign tdata  = {5'b0, ouser_q[3:1], odata_q};
	assign tuser  = ouser_q[0];
	assign tlast  = ouser_q[4];

endmodule

[rtl/limit_order_book_matcher.sv]
// Top level of the price-time priority limit order book matcher.
// Results: a cancel or an order without fills shows its one result; each fill adds
//   one more walk of the slot store before the next item.
// Requests: one at a time; the next is accepted once the last has issued its final
//   item, and acceptance waits while m_tready is held low.
// Reset: arst_n clears all slot valid bits, the arrival counter and all
//   control state at once; slot contents stay undefined until written.
module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int unsigned ORDER_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// side[0] limit_price[32:1] quantity[64:33] oid[128:65]
	// trader_id[160:129] timestamp[224:161], zero fill to 232
	input  logic [231:0] s_tdata,
	// req_type
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// buyer_trader[31:0] seller_trader[63:32] fill_price[95:64]
	// fill_qty[127:96] fill_time[191:128] status[194:192], zero fill to 200
	output logic [199:0] m_tdata,
	// is_trade
	output logic         m_tuser,
	output logic         m_tlast
);

	lobm_cmd_t    cmd;
	lobm_sts_t    sts;
	logic         dp_valid, dp_take;
	logic [191:0] dp_data;
	logic [4:0]   dp_user;

	// Sequencer: walk the store, pick the action, pace the result items.
	lobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: slot memory, scan accumulators, fill arithmetic.
	lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_req    (s_tuser),
		.in_data   (s_tdata[224:0]),
		.out_take  (dp_take),
		.out_valid (dp_valid),
		.out_data  (dp_data),
		.out_user  (dp_user)
	);

	// Merge the final status onto the last fill, then drive the master side.
	lobm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dp_valid),
		.in_data  (dp_data),
		.in_user  (dp_user),
		.in_take  (dp_take),
		.tvalid   (m_tvalid),
		.tready   (m_tready),
		.tdata    (m_tdata),
		.tuser    (m_tuser),
		.tlast    (m_tlast)
	);

endmodule
